// ===== rtl/core/ssdr_pkg.sv =====
// Shared types and constants for the sunrise/sunset dimming ramp.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ssdr_pkg;

  // Field widths of the channels and the configuration port.
  localparam int TIME_W     = 17;
  localparam int DUTY_W     = 12;
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Widths of the configuration registers.
  localparam int MIN_W  = 11;
  localparam int LEN_W  = 10;
  localparam int PCT_W  = 7;
  localparam int STEP_W = 12;

  // A ramp length in seconds: at most 1023 minutes of 60 seconds.
  localparam int RAMP_W = 16;

  // Default full-scale duty.
  localparam int DUTY_FULL_SCALE_DEF = 4095;

  // Percent scale of max_percent.
  localparam int PCT_SCALE = 100;

  // floor(y / 100) for y below 10000 as (y * RECIP_MUL) >> RECIP_SHIFT.
  localparam int PCT_R_W     = 14;
  localparam int RECIP_MUL   = 10486;
  localparam int RECIP_SHIFT = 20;
  localparam int PCT_Q_W     = 7;

  // Last minute of the day.
  localparam logic [MIN_W-1:0] LAST_MINUTE = 11'd1439;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_LEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_END    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_LEN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PCT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [MIN_W-1:0]  RST_RISE_START = 11'd480;
  localparam logic [LEN_W-1:0]  RST_RISE_LEN   = 10'd60;
  localparam logic [MIN_W-1:0]  RST_SET_END    = 11'd1200;
  localparam logic [LEN_W-1:0]  RST_SET_LEN    = 10'd60;
  localparam logic [PCT_W-1:0]  RST_MAX_PCT    = 7'd100;
  localparam logic [STEP_W-1:0] RST_STEP       = 12'd60;

  // Day phase as reported on the output.
  typedef enum logic [PHASE_W-1:0] {
    PH_NIGHT = 2'd0,
    PH_RISE  = 2'd1,
    PH_FULL  = 2'd2,
    PH_SET   = 2'd3
  } phase_t;

  // Configuration register set.
  typedef struct packed {
    logic [MIN_W-1:0]  rise_start_min;
    logic [LEN_W-1:0]  rise_len_min;
    logic [MIN_W-1:0]  set_end_min;
    logic [LEN_W-1:0]  set_len_min;
    logic [PCT_W-1:0]  max_percent;
    logic [STEP_W-1:0] step_seconds;
  } cfg_t;

endpackage

// ===== rtl/core/ssdr_ifs.sv =====
// Valid/ready channel interfaces for time samples and duty results.
// Depends on ssdr_pkg for the field widths.
`timescale 1ns / 1ps

interface ssdr_in_if import ssdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_of_day_s;

  modport source (output valid, output time_of_day_s, input ready);
  modport sink   (input valid, input time_of_day_s, output ready);
endinterface

interface ssdr_out_if import ssdr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DUTY_W-1:0]  duty;
  logic [PHASE_W-1:0] phase;

  modport source (output valid, output duty, output phase, input ready);
  modport sink   (input valid, input duty, input phase, output ready);
endinterface

// ===== rtl/core/ssdr_cell.sv =====
// One cell of the divider row: a restoring step for two quotients at once.
// Depends on ssdr_pkg; instantiated in a chain by the top level.
`timescale 1ns / 1ps

module ssdr_cell import ssdr_pkg::*; #(
  parameter int NW = 28,
  parameter int DA = 12,
  parameter int DB = 16,
  parameter int SW = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num_a,
  input  logic [DA-1:0] in_rem_a,
  input  logic [DA-1:0] in_div_a,
  input  logic [NW-1:0] in_num_b,
  input  logic [DB-1:0] in_rem_b,
  input  logic [DB-1:0] in_div_b,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_num_a,
  output logic [DA-1:0] out_rem_a,
  output logic [DA-1:0] out_div_a,
  output logic [NW-1:0] out_num_b,
  output logic [DB-1:0] out_rem_b,
  output logic [DB-1:0] out_div_b,
  output logic [SW-1:0] out_side
);

  logic [DA:0]   trial_a;
  logic [DA:0]   diff_a;
  logic          ge_a;
  logic [DB:0]   trial_b;
  logic [DB:0]   diff_b;
  logic          ge_b;
  logic [DA-1:0] rem_a_next;
  logic [DB-1:0] rem_b_next;

  // Bring down the next dividend bit and subtract the divisor if it fits.
  // The remainder stays below the divisor, so it keeps the divisor's width.
  always_comb begin
    trial_a    = {in_rem_a, in_num_a[NW-1]};
    diff_a     = trial_a - {1'b0, in_div_a};
    ge_a       = trial_a >= {1'b0, in_div_a};
    rem_a_next = ge_a ? diff_a[DA-1:0] : trial_a[DA-1:0];
    trial_b    = {in_rem_b, in_num_b[NW-1]};
    diff_b     = trial_b - {1'b0, in_div_b};
    ge_b       = trial_b >= {1'b0, in_div_b};
    rem_b_next = ge_b ? diff_b[DB-1:0] : trial_b[DB-1:0];
  end

  // The dividend shifts out at the top while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_num_a <= {in_num_a[NW-2:0], ge_a};
      out_rem_a <= rem_a_next;
      out_div_a <= in_div_a;
      out_num_b <= {in_num_b[NW-2:0], ge_b};
      out_rem_b <= rem_b_next;
      out_div_b <= in_div_b;
      out_side  <= in_side;
    end
  end

endmodule

// ===== rtl/core/ssdr_front.sv =====
// Front stages: window bounds, phase, elapsed time, peak duty and the
// peak * step product that feeds the divider row. Depends on ssdr_pkg.
`timescale 1ns / 1ps

module ssdr_front import ssdr_pkg::*; #(
  parameter int FULL_SCALE = DUTY_FULL_SCALE_DEF,
  localparam int PW = $clog2(FULL_SCALE + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [TIME_W-1:0]    in_time,
  input  cfg_t                 cfg,
  output logic                 out_valid,
  output phase_t               out_phase,
  output logic [PW-1:0]        out_peak,
  output logic [TIME_W-1:0]    out_elapsed,
  output logic [STEP_W-1:0]    out_step,
  output logic [PW+STEP_W-1:0] out_prod,
  output logic [RAMP_W-1:0]    out_ramp
);

  // pct * FULL_SCALE / 100 = pct * Q + floor(pct * R / 100).
  localparam int FS_Q = FULL_SCALE / PCT_SCALE;
  localparam int FS_R = FULL_SCALE % PCT_SCALE;
  localparam int Y_W  = 2 * PCT_R_W;

  // Minutes to seconds: m * 60 = m * 64 - m * 4.
  function automatic logic [TIME_W-1:0] min_to_s(input logic [MIN_W-1:0] m);
    return (TIME_W'(m) << 6) - (TIME_W'(m) << 2);
  endfunction

  function automatic logic [RAMP_W-1:0] len_to_s(input logic [LEN_W-1:0] l);
    return (RAMP_W'(l) << 6) - (RAMP_W'(l) << 2);
  endfunction

  logic [MIN_W-1:0]  rs_min;
  logic [MIN_W-1:0]  se_min;
  logic [MIN_W-1:0]  re_min;
  logic [MIN_W-1:0]  ss_min;
  logic [MIN_W:0]    re_sum;
  logic [LEN_W-1:0]  rlen;
  logic [LEN_W-1:0]  slen;
  logic [PCT_W-1:0]  pct;
  logic [STEP_W-1:0] stp;

  // Clamp the register values and work out the window bounds in minutes.
  always_comb begin
    rs_min = (cfg.rise_start_min > LAST_MINUTE) ? LAST_MINUTE : cfg.rise_start_min;
    se_min = (cfg.set_end_min > LAST_MINUTE) ? LAST_MINUTE : cfg.set_end_min;
    rlen   = (cfg.rise_len_min == '0) ? LEN_W'(1) : cfg.rise_len_min;
    slen   = (cfg.set_len_min == '0) ? LEN_W'(1) : cfg.set_len_min;
    re_sum = (MIN_W + 1)'(rs_min) + (MIN_W + 1)'(rlen);
    re_min = (re_sum > (MIN_W + 1)'(LAST_MINUTE)) ? LAST_MINUTE : re_sum[MIN_W-1:0];
    ss_min = (se_min > MIN_W'(slen)) ? se_min - MIN_W'(slen) : '0;
    pct    = (cfg.max_percent > PCT_W'(PCT_SCALE)) ? PCT_W'(PCT_SCALE) : cfg.max_percent;
    stp    = (cfg.step_seconds == '0) ? STEP_W'(1) : cfg.step_seconds;
  end

  // Stage 1: the accepted time with the bounds in seconds.
  logic                 s1_valid;
  logic [TIME_W-1:0]    s1_time;
  logic [TIME_W-1:0]    s1_rise_start;
  logic [TIME_W-1:0]    s1_rise_end;
  logic [TIME_W-1:0]    s1_set_start;
  logic [TIME_W-1:0]    s1_set_end;
  logic [RAMP_W-1:0]    s1_rise_s;
  logic [RAMP_W-1:0]    s1_set_s;
  logic [PW-1:0]        s1_pct_q;
  logic [PCT_R_W-1:0]   s1_pct_r;
  logic [STEP_W-1:0]    s1_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_time       <= in_time;
      s1_rise_start <= min_to_s(rs_min);
      s1_rise_end   <= min_to_s(re_min);
      s1_set_start  <= min_to_s(ss_min);
      s1_set_end    <= min_to_s(se_min);
      s1_rise_s     <= len_to_s(rlen);
      s1_set_s      <= len_to_s(slen);
      s1_pct_q      <= PW'(PW'(pct) * PW'(FS_Q));
      s1_pct_r      <= PCT_R_W'(PCT_R_W'(pct) * PCT_R_W'(FS_R));
      s1_step       <= stp;
    end
  end

  // Stage 2: window checks in order, elapsed time and the peak remainder.
  phase_t            phase2;
  logic [TIME_W-1:0] elapsed2;
  logic [RAMP_W-1:0] ramp2;
  logic [Y_W-1:0]    y_mul;

  always_comb begin
    if (s1_rise_start <= s1_time && s1_time <= s1_rise_end) begin
      phase2 = PH_RISE;
    end else if (s1_rise_end <= s1_time && s1_time <= s1_set_start) begin
      phase2 = PH_FULL;
    end else if (s1_set_start <= s1_time && s1_time <= s1_set_end) begin
      phase2 = PH_SET;
    end else begin
      phase2 = PH_NIGHT;
    end
    elapsed2 = (phase2 == PH_RISE) ? s1_time - s1_rise_start : s1_time - s1_set_start;
    ramp2    = (phase2 == PH_SET) ? s1_set_s : s1_rise_s;
    y_mul    = Y_W'(s1_pct_r) * Y_W'(RECIP_MUL);
  end

  logic                 s2_valid;
  phase_t               s2_phase;
  logic [TIME_W-1:0]    s2_elapsed;
  logic [RAMP_W-1:0]    s2_ramp;
  logic [PW-1:0]        s2_pct_q;
  logic [PCT_Q_W-1:0]   s2_yq;
  logic [STEP_W-1:0]    s2_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_phase   <= phase2;
      s2_elapsed <= elapsed2;
      s2_ramp    <= ramp2;
      s2_pct_q   <= s1_pct_q;
      s2_yq      <= y_mul[RECIP_SHIFT +: PCT_Q_W];
      s2_step    <= s1_step;
    end
  end

  // Stage 3: the peak duty.
  logic                 s3_valid;
  phase_t               s3_phase;
  logic [TIME_W-1:0]    s3_elapsed;
  logic [RAMP_W-1:0]    s3_ramp;
  logic [PW-1:0]        s3_peak;
  logic [STEP_W-1:0]    s3_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
    if (en) begin
      s3_phase   <= s2_phase;
      s3_elapsed <= s2_elapsed;
      s3_ramp    <= s2_ramp;
      s3_peak    <= s2_pct_q + PW'(s2_yq);
      s3_step    <= s2_step;
    end
  end

  // Stage 4: peak * step, the dividend of the per-step increment.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s3_valid;
    end
    if (en) begin
      out_phase   <= s3_phase;
      out_elapsed <= s3_elapsed;
      out_ramp    <= s3_ramp;
      out_peak    <= s3_peak;
      out_step    <= s3_step;
      out_prod    <= (PW + STEP_W)'(s3_peak) * (PW + STEP_W)'(s3_step);
    end
  end

endmodule

// ===== rtl/core/sunrise_sunset_dimming_ramp.sv =====
// Top level of the sunrise/sunset dimming ramp: configuration registers,
// front stages, divider cell row, result stages and output skid register.
// Depends on ssdr_pkg, ssdr_ifs, ssdr_front and ssdr_cell.
//
//   channel   dir  handshake          payload
//   in_ch     in   valid/ready        time_of_day_s[16:0]
//   out_ch    out  valid/ready        duty[11:0], phase[1:0]
//   cfg       in   cfg_we (no ready)  cfg_index[2:0], cfg_data[11:0]
//
// One item enters in every cycle while the skid register is empty. NW is the
// width of peak * step (24 at the default full scale). The path has four front
// stages, one divider cell per quotient bit and three result stages.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// A result that is not taken moves into the skid register; in_ch.ready then
// drops until the skid register has been emptied.
`timescale 1ns / 1ps

module sunrise_sunset_dimming_ramp import ssdr_pkg::*; #(
  parameter int DUTY_FULL_SCALE = DUTY_FULL_SCALE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  ssdr_in_if.sink               in_ch,
  ssdr_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PW = $clog2(DUTY_FULL_SCALE + 1);
  localparam int NW = PW + STEP_W;
  localparam int SW = PW + PHASE_W;

  // Configuration registers.
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rise_start_min <= RST_RISE_START;
      cfg.rise_len_min   <= RST_RISE_LEN;
      cfg.set_end_min    <= RST_SET_END;
      cfg.set_len_min    <= RST_SET_LEN;
      cfg.max_percent    <= RST_MAX_PCT;
      cfg.step_seconds   <= RST_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RISE_START: cfg.rise_start_min <= cfg_data[MIN_W-1:0];
        CFG_RISE_LEN:   cfg.rise_len_min   <= cfg_data[LEN_W-1:0];
        CFG_SET_END:    cfg.set_end_min    <= cfg_data[MIN_W-1:0];
        CFG_SET_LEN:    cfg.set_len_min    <= cfg_data[LEN_W-1:0];
        CFG_MAX_PCT:    cfg.max_percent    <= cfg_data[PCT_W-1:0];
        CFG_STEP:       cfg.step_seconds   <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless the skid register holds a result.
  logic skid_valid;
  logic en;

  assign en          = !skid_valid;
  assign in_ch.ready = en;

  // Front stages.
  logic                 f_valid;
  phase_t               f_phase;
  logic [PW-1:0]        f_peak;
  logic [TIME_W-1:0]    f_elapsed;
  logic [STEP_W-1:0]    f_step;
  logic [NW-1:0]        f_prod;
  logic [RAMP_W-1:0]    f_ramp;

  ssdr_front #(
    .FULL_SCALE (DUTY_FULL_SCALE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (in_ch.valid),
    .in_time     (in_ch.time_of_day_s),
    .cfg         (cfg),
    .out_valid   (f_valid),
    .out_phase   (f_phase),
    .out_peak    (f_peak),
    .out_elapsed (f_elapsed),
    .out_step    (f_step),
    .out_prod    (f_prod),
    .out_ramp    (f_ramp)
  );

  // Divider row: lane A gives elapsed / step, lane B gives peak*step / ramp.
  logic              c_valid [0:NW];
  logic [NW-1:0]     c_num_a [0:NW];
  logic [STEP_W-1:0] c_rem_a [0:NW];
  logic [STEP_W-1:0] c_div_a [0:NW];
  logic [NW-1:0]     c_num_b [0:NW];
  logic [RAMP_W-1:0] c_rem_b [0:NW];
  logic [RAMP_W-1:0] c_div_b [0:NW];
  logic [SW-1:0]     c_side  [0:NW];

  assign c_valid[0] = f_valid;
  assign c_num_a[0] = NW'(f_elapsed);
  assign c_rem_a[0] = '0;
  assign c_div_a[0] = f_step;
  assign c_num_b[0] = f_prod;
  assign c_rem_b[0] = '0;
  assign c_div_b[0] = f_ramp;
  assign c_side[0]  = {f_phase, f_peak};

  for (genvar i = 0; i < NW; i++) begin : g_cell
    ssdr_cell #(
      .NW (NW),
      .DA (STEP_W),
      .DB (RAMP_W),
      .SW (SW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (c_valid[i]),
      .in_num_a  (c_num_a[i]),
      .in_rem_a  (c_rem_a[i]),
      .in_div_a  (c_div_a[i]),
      .in_num_b  (c_num_b[i]),
      .in_rem_b  (c_rem_b[i]),
      .in_div_b  (c_div_b[i]),
      .in_side   (c_side[i]),
      .out_valid (c_valid[i+1]),
      .out_num_a (c_num_a[i+1]),
      .out_rem_a (c_rem_a[i+1]),
      .out_div_a (c_div_a[i+1]),
      .out_num_b (c_num_b[i+1]),
      .out_rem_b (c_rem_b[i+1]),
      .out_div_b (c_div_b[i+1]),
      .out_side  (c_side[i+1])
    );
  end

  // Result stage 1: saturate both quotients to the peak width. A saturated
  // factor times a nonzero one is still at least the peak, so the clamp
  // below gives the same duty.
  logic          p1_valid;
  logic [PW-1:0] p1_steps;
  logic [PW-1:0] p1_delta;
  logic [PW-1:0] p1_peak;
  phase_t        p1_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= c_valid[NW];
    end
    if (en) begin
      p1_steps <= ((c_num_a[NW] >> PW) != '0) ? '1 : c_num_a[NW][PW-1:0];
      p1_delta <= ((c_num_b[NW] >> PW) != '0) ? '1 : c_num_b[NW][PW-1:0];
      p1_peak  <= c_side[NW][PW-1:0];
      p1_phase <= phase_t'(c_side[NW][PW +: PHASE_W]);
    end
  end

  // Result stage 2: the stepped ramp term.
  logic            p2_valid;
  logic [2*PW-1:0] p2_term;
  logic [PW-1:0]   p2_peak;
  phase_t          p2_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
    if (en) begin
      p2_term  <= (2 * PW)'(p1_steps) * (2 * PW)'(p1_delta);
      p2_peak  <= p1_peak;
      p2_phase <= p1_phase;
    end
  end

  // Result stage 3: duty by phase, clamped to 0..peak.
  logic          term_ge_peak;
  logic [PW-1:0] duty_sel;

  always_comb begin
    term_ge_peak = p2_term >= (2 * PW)'(p2_peak);
    case (p2_phase)
      PH_RISE: duty_sel = term_ge_peak ? p2_peak : p2_term[PW-1:0];
      PH_FULL: duty_sel = p2_peak;
      PH_SET:  duty_sel = term_ge_peak ? '0 : p2_peak - p2_term[PW-1:0];
      default: duty_sel = '0;
    endcase
  end

  logic              fin_valid;
  logic [DUTY_W-1:0] fin_duty;
  phase_t            fin_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= p2_valid;
    end
    if (en) begin
      fin_duty  <= DUTY_W'(duty_sel);
      fin_phase <= p2_phase;
    end
  end

  // Skid register: catches the last stage's item when the output stalls.
  logic [DUTY_W-1:0] skid_duty;
  phase_t            skid_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ch.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (fin_valid && !out_ch.ready) begin
      skid_valid <= 1'b1;
    end
    if (!skid_valid) begin
      skid_duty  <= fin_duty;
      skid_phase <= fin_phase;
    end
  end

  assign out_ch.valid = skid_valid || fin_valid;
  assign out_ch.duty  = skid_valid ? skid_duty : fin_duty;
  assign out_ch.phase = skid_valid ? PHASE_W'(skid_phase) : PHASE_W'(fin_phase);

  // The skid register only fills from a stalled result.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(fin_valid && !out_ch.ready))
    else $error("skid register filled without a stalled result");

  // While the skid register is full the last stage must hold its item.
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    skid_valid |=> $stable(fin_valid) && $stable(fin_duty))
    else $error("last stage moved while the skid register was full");

  // A night result never lights the lamp.
  a_night_dark: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.phase == PH_NIGHT) |-> (out_ch.duty == '0))
    else $error("nonzero duty reported at night");

endmodule
